### sv/multicolor_langton_ant_stepper_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multicolor ant stepper
// Shorthand for clocked checks; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MULTICOLOR_LANGTON_ANT_STEPPER_UNIT_MACROS_SVH
`define MULTICOLOR_LANGTON_ANT_STEPPER_UNIT_MACROS_SVH

// Check that a condition holds at every edge out of reset
`define MLAS_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a same-cycle implication
`define MLAS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication
`define MLAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mlas_pkg.sv
// ----------------------------------------------------------------------------
// mlas_pkg
// Shared types and codes for the multicolor ant stepper.
// ----------------------------------------------------------------------------
package mlas_pkg;

    // Fixed field widths of the ports
    localparam int PORT_COORD_W = 8;
    localparam int PORT_INDEX_W = 3;
    localparam int COLOR_W      = 3;
    localparam int DIR_W        = 2;
    localparam int RULE_W       = 7;
    localparam int PLACE_RANGE  = 1 << PORT_COORD_W;

    // Command codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    // Cell codes
    localparam logic [COLOR_W-1:0] COLOR_UNVISITED = 3'd0;
    localparam logic [COLOR_W-1:0] COLOR_WHITE     = 3'd1;
    localparam logic [COLOR_W-1:0] COLOR_GREY      = 3'd7;

    // Headings
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

    localparam logic [RULE_W-1:0] TURN_RULE_RESET = 7'd99;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TICK_CELL,
        ST_TICK_WB,
        ST_PLACE_CMP,
        ST_PLACE_WB,
        ST_EMPTY
    } state_t;

endpackage

### sv/mlas_ram.sv
// ----------------------------------------------------------------------------
// mlas_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mlas_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/mlas_step.sv
// ----------------------------------------------------------------------------
// mlas_step
// One ant step: recolor the cell, turn by the rule, move with wrap-around.
// ----------------------------------------------------------------------------
module mlas_step
    import mlas_pkg::*;
#(
    parameter int GRID_SIZE = 256,
    parameter int CW        = $clog2(GRID_SIZE)
) (
    input  logic [COLOR_W-1:0] cell_in,
    input  logic [CW-1:0]      x_in,
    input  logic [CW-1:0]      y_in,
    input  logic [DIR_W-1:0]   dir_in,
    input  logic [RULE_W-1:0]  turn_rule,
    output logic [COLOR_W-1:0] cell_out,
    output logic [CW-1:0]      x_out,
    output logic [CW-1:0]      y_out,
    output logic [DIR_W-1:0]   dir_out
);

    localparam logic [CW-1:0] EDGE_MAX = CW'(GRID_SIZE - 1);

    logic turn_right;

    // Advance the color; unvisited and grey both go to white
    always_comb
    begin
        if (cell_in == COLOR_UNVISITED || cell_in == COLOR_GREY)
        begin
            cell_out = COLOR_WHITE;
        end
        else
        begin
            cell_out = cell_in + COLOR_W'(1);
        end
    end

    // Turn by the rule bit of the new color
    assign turn_right = turn_rule[cell_out - COLOR_W'(1)];
    assign dir_out    = turn_right ? (dir_in + DIR_W'(1)) : (dir_in - DIR_W'(1));

    // Move one cell forward, wrapping at the edges
    always_comb
    begin
        x_out = x_in;
        y_out = y_in;
        unique case (dir_out)
            DIR_UP:    y_out = (y_in == '0) ? EDGE_MAX : (y_in - CW'(1));
            DIR_RIGHT: x_out = (x_in == EDGE_MAX) ? '0 : (x_in + CW'(1));
            DIR_DOWN:  y_out = (y_in == EDGE_MAX) ? '0 : (y_in + CW'(1));
            DIR_LEFT:  x_out = (x_in == '0) ? EDGE_MAX : (x_in - CW'(1));
        endcase
    end

endmodule

### sv/multicolor_langton_ant_stepper_unit.sv
// ----------------------------------------------------------------------------
// multicolor_langton_ant_stepper_unit
// Steps up to MAX_ANTS ants on a wrapping grid of seven-color cells.
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell memory to unvisited, one entry per
// cycle, over all 4^ceil(log2(GRID_SIZE)) entries (65536 at the defaults),
// with in_stall high; turn_rule writes are taken throughout. A tick steps
// each placed ant in turn: it reads its cell from the single-read-port
// cell memory, then writes the new color back once the output register is
// free, while the next ant's entry is fetched from the ant table in the
// shadow of the cell read. A tick with no ants gives one empty beat. A place
// command scans the ant table one entry per cycle for a clash, skipping the
// scan when the table is empty or full. A finished beat waits in the output
// register, and the next command is taken while it waits.
`include "multicolor_langton_ant_stepper_unit_macros.svh"

module multicolor_langton_ant_stepper_unit
    import mlas_pkg::*;
#(
    parameter int GRID_SIZE = 256,
    parameter int MAX_ANTS  = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [RULE_W-1:0]       cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    opcode,
    input  logic [PORT_COORD_W-1:0] place_x,
    input  logic [PORT_COORD_W-1:0] place_y,
    input  logic [DIR_W-1:0]        place_dir,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [PORT_INDEX_W-1:0] ant_index,
    output logic [PORT_COORD_W-1:0] ant_x,
    output logic [PORT_COORD_W-1:0] ant_y,
    output logic [DIR_W-1:0]        ant_dir,
    output logic [COLOR_W-1:0]      cell_color,
    output logic                    accepted,
    output logic                    last
);

    localparam int CW         = $clog2(GRID_SIZE);
    localparam int GA_W       = 2 * CW;
    localparam int GRID_DEPTH = 1 << GA_W;
    localparam int AW         = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
    localparam int CNW        = $clog2(MAX_ANTS + 1);
    localparam int ANT_W      = 2 * CW + DIR_W;

    // Control state
    state_t               state_reg, state_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CNW-1:0]       count_reg, count_next;
    logic [GA_W-1:0]      clr_reg, clr_next;
    logic                 clash_reg, clash_next;
    logic [RULE_W-1:0]    turn_rule_reg, turn_rule_next;
    logic                 out_valid_reg, out_valid_next;

    // Working payload
    logic [CW-1:0]        cur_x_reg, cur_x_next;
    logic [CW-1:0]        cur_y_reg, cur_y_next;
    logic [DIR_W-1:0]     cur_d_reg, cur_d_next;
    logic [CW-1:0]        px_reg, px_next;
    logic [CW-1:0]        py_reg, py_next;
    logic [DIR_W-1:0]     pd_reg, pd_next;

    // Output payload
    logic [PORT_INDEX_W-1:0] o_index_reg, o_index_next;
    logic [PORT_COORD_W-1:0] o_x_reg, o_x_next;
    logic [PORT_COORD_W-1:0] o_y_reg, o_y_next;
    logic [DIR_W-1:0]        o_dir_reg, o_dir_next;
    logic [COLOR_W-1:0]      o_color_reg, o_color_next;
    logic                    o_acc_reg, o_acc_next;
    logic                    o_last_reg, o_last_next;

    // Memory ports
    logic                 cell_we, cell_re;
    logic [GA_W-1:0]      cell_waddr, cell_raddr;
    logic [COLOR_W-1:0]   cell_wdata, cell_q;
    logic                 ant_we, ant_re;
    logic [AW-1:0]        ant_waddr, ant_raddr;
    logic [ANT_W-1:0]     ant_wdata, ant_q;

    // Helpers
    logic                 in_accept, out_free, load_out;
    logic                 clear_done, idx_last, count_zero, full, reject;
    logic [CW-1:0]        ant_x_q, ant_y_q;
    logic [DIR_W-1:0]     ant_d_q;
    logic [COLOR_W-1:0]   step_color;
    logic [CW-1:0]        step_x, step_y;
    logic [DIR_W-1:0]     step_dir;
    logic [CW-1:0]        mod_tab [PLACE_RANGE];

    // Fold placement coordinates into the grid
    genvar gv;
    for (gv = 0; gv < PLACE_RANGE; gv++)
    begin : g_mod
        assign mod_tab[gv] = CW'(gv % GRID_SIZE);
    end

    // Cell memory: one code per cell, addressed by row then column
    mlas_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (GRID_DEPTH),
        .ADDR_W(GA_W)
    ) u_cell_ram (
        .clk    (clk),
        .wr_en  (cell_we),
        .wr_addr(cell_waddr),
        .wr_data(cell_wdata),
        .rd_en  (cell_re),
        .rd_addr(cell_raddr),
        .rd_data(cell_q)
    );

    // Ant table: column, row, heading per ant
    mlas_ram #(
        .WIDTH (ANT_W),
        .DEPTH (MAX_ANTS),
        .ADDR_W(AW)
    ) u_ant_ram (
        .clk    (clk),
        .wr_en  (ant_we),
        .wr_addr(ant_waddr),
        .wr_data(ant_wdata),
        .rd_en  (ant_re),
        .rd_addr(ant_raddr),
        .rd_data(ant_q)
    );

    assign ant_x_q = ant_q[ANT_W-1 -: CW];
    assign ant_y_q = ant_q[DIR_W +: CW];
    assign ant_d_q = ant_q[DIR_W-1:0];

    // Step the current ant from its cell code
    mlas_step #(
        .GRID_SIZE(GRID_SIZE),
        .CW       (CW)
    ) u_step (
        .cell_in  (cell_q),
        .x_in     (cur_x_reg),
        .y_in     (cur_y_reg),
        .dir_in   (cur_d_reg),
        .turn_rule(turn_rule_reg),
        .cell_out (step_color),
        .x_out    (step_x),
        .y_out    (step_y),
        .dir_out  (step_dir)
    );

    // Handshake and status terms
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign clear_done = &clr_reg;
    assign idx_last   = ((CNW'(idx_reg) + CNW'(1)) == count_reg);
    assign count_zero = (count_reg == '0);
    assign full       = (count_reg == CNW'(MAX_ANTS));
    assign reject     = clash_reg || full;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (opcode == OP_PLACE)
                    begin
                        state_next = (full || count_zero) ? ST_PLACE_WB : ST_PLACE_CMP;
                    end
                    else
                    begin
                        state_next = count_zero ? ST_EMPTY : ST_TICK_CELL;
                    end
                end
            end
            ST_TICK_CELL:
            begin
                state_next = ST_TICK_WB;
            end
            ST_TICK_WB:
            begin
                if (out_free)
                begin
                    state_next = idx_last ? ST_IDLE : ST_TICK_CELL;
                end
            end
            ST_PLACE_CMP:
            begin
                if (idx_last)
                begin
                    state_next = ST_PLACE_WB;
                end
            end
            ST_PLACE_WB, ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory controls and output load
    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = '0;
        cell_wdata = COLOR_UNVISITED;
        cell_re    = 1'b0;
        cell_raddr = '0;
        ant_we     = 1'b0;
        ant_waddr  = '0;
        ant_wdata  = '0;
        ant_re     = 1'b0;
        ant_raddr  = '0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_reg;
            end
            ST_IDLE:
            begin
                // Fetch the first ant for a tick or a clash scan
                if (in_accept && !count_zero && !(opcode == OP_PLACE && full))
                begin
                    ant_re = 1'b1;
                end
            end
            ST_TICK_CELL:
            begin
                cell_re    = 1'b1;
                cell_raddr = {ant_y_q, ant_x_q};
                if (!idx_last)
                begin
                    ant_re    = 1'b1;
                    ant_raddr = idx_reg + AW'(1);
                end
            end
            ST_TICK_WB:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    cell_we    = 1'b1;
                    cell_waddr = {cur_y_reg, cur_x_reg};
                    cell_wdata = step_color;
                    ant_we     = 1'b1;
                    ant_waddr  = idx_reg;
                    ant_wdata  = {step_x, step_y, step_dir};
                end
            end
            ST_PLACE_CMP:
            begin
                if (!idx_last)
                begin
                    ant_re    = 1'b1;
                    ant_raddr = idx_reg + AW'(1);
                end
            end
            ST_PLACE_WB:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (!reject)
                    begin
                        ant_we     = 1'b1;
                        ant_waddr  = AW'(count_reg);
                        ant_wdata  = {px_reg, py_reg, pd_reg};
                        cell_we    = 1'b1;
                        cell_waddr = {py_reg, px_reg};
                        cell_wdata = COLOR_WHITE;
                    end
                end
            end
            ST_EMPTY:
            begin
                load_out = out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        idx_next     = idx_reg;
        count_next   = count_reg;
        clr_next     = clr_reg;
        clash_next   = clash_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        cur_d_next   = cur_d_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pd_next      = pd_reg;
        o_index_next = o_index_reg;
        o_x_next     = o_x_reg;
        o_y_next     = o_y_reg;
        o_dir_next   = o_dir_reg;
        o_color_next = o_color_reg;
        o_acc_next   = o_acc_reg;
        o_last_next  = o_last_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + GA_W'(1);
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next   = '0;
                    clash_next = 1'b0;
                    px_next    = mod_tab[place_x];
                    py_next    = mod_tab[place_y];
                    pd_next    = place_dir;
                end
            end
            ST_TICK_CELL:
            begin
                cur_x_next = ant_x_q;
                cur_y_next = ant_y_q;
                cur_d_next = ant_d_q;
            end
            ST_TICK_WB:
            begin
                if (out_free)
                begin
                    idx_next     = idx_reg + AW'(1);
                    o_index_next = PORT_INDEX_W'(idx_reg);
                    o_x_next     = PORT_COORD_W'(step_x);
                    o_y_next     = PORT_COORD_W'(step_y);
                    o_dir_next   = step_dir;
                    o_color_next = step_color;
                    o_acc_next   = 1'b1;
                    o_last_next  = idx_last;
                end
            end
            ST_PLACE_CMP:
            begin
                if (ant_x_q == px_reg && ant_y_q == py_reg)
                begin
                    clash_next = 1'b1;
                end
                if (!idx_last)
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_PLACE_WB:
            begin
                if (out_free)
                begin
                    o_index_next = reject ? '0 : PORT_INDEX_W'(count_reg);
                    o_x_next     = PORT_COORD_W'(px_reg);
                    o_y_next     = PORT_COORD_W'(py_reg);
                    o_dir_next   = pd_reg;
                    o_color_next = reject ? COLOR_UNVISITED : COLOR_WHITE;
                    o_acc_next   = !reject;
                    o_last_next  = 1'b1;
                    if (!reject)
                    begin
                        count_next = count_reg + CNW'(1);
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    o_index_next = '0;
                    o_x_next     = '0;
                    o_y_next     = '0;
                    o_dir_next   = '0;
                    o_color_next = COLOR_UNVISITED;
                    o_acc_next   = 1'b0;
                    o_last_next  = 1'b1;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    // Take configuration writes at any time
    assign turn_rule_next = cfg_wr_en ? cfg_wr_data : turn_rule_reg;

    // Hold the output beat until taken
    assign out_valid_next = (out_valid_reg && out_stall) || load_out;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            clash_reg     <= 1'b0;
            turn_rule_reg <= TURN_RULE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            clash_reg     <= clash_next;
            turn_rule_reg <= turn_rule_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        cur_d_reg   <= cur_d_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        pd_reg      <= pd_next;
        o_index_reg <= o_index_next;
        o_x_reg     <= o_x_next;
        o_y_reg     <= o_y_next;
        o_dir_reg   <= o_dir_next;
        o_color_reg <= o_color_next;
        o_acc_reg   <= o_acc_next;
        o_last_reg  <= o_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign ant_index  = o_index_reg;
    assign ant_x      = o_x_reg;
    assign ant_y      = o_y_reg;
    assign ant_dir    = o_dir_reg;
    assign cell_color = o_color_reg;
    assign accepted   = o_acc_reg;
    assign last       = o_last_reg;

    // Checks
    `MLAS_ASSERT_HOLDS(a_count_bound, count_reg <= CNW'(MAX_ANTS), "ant count exceeds table size")
    `MLAS_ASSERT_IMPLIES(a_paint_nonzero, cell_we && state_reg != ST_CLEAR,
        cell_wdata != COLOR_UNVISITED, "cell painted unvisited outside the clearing pass")
    `MLAS_ASSERT_NEXT(a_place_grows, state_reg == ST_PLACE_WB && load_out && !reject,
        count_reg == $past(count_reg) + CNW'(1), "accepted placement did not add an ant")
    `MLAS_ASSERT_IMPLIES(a_quiet_clear, state_reg == ST_CLEAR, !out_valid_reg,
        "result beat during the clearing pass")

endmodule
